// ===== rtl/wbps_pkg.sv =====
package wbps_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd6;

  // Pattern storage held in registers
  localparam int unsigned REG_PAT_BYTES = 32;
  localparam int unsigned PAT_VEC_W     = REG_PAT_BYTES * 8;
  localparam int unsigned PLEN_REG_W    = 6;
  // Effective length width: covers every allowed window depth (up to 64)
  localparam int unsigned LEN_W         = 7;
  localparam int unsigned POS_W         = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic load;   // take the neighbor's byte
    logic clear;  // region ended: back to zero
  } cell_ctrl_t;

  // Pattern byte at a position; positions past the registers read as zero
  function automatic logic [7:0] pat_byte(input logic [PAT_VEC_W-1:0] pat,
                                          input logic [POS_W-1:0] pos);
    logic [7:0] b;
    if (pos[POS_W-1]) begin
      b = 8'h00;
    end else begin
      b = pat[{pos[POS_W-2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  // Wildcard flag at a position; positions past the registers never match all
  function automatic logic pat_wild(input logic [REG_PAT_BYTES-1:0] mask,
                                    input logic [POS_W-1:0] pos);
    logic w;
    if (pos[POS_W-1]) begin
      w = 1'b0;
    end else begin
      w = mask[pos[POS_W-2:0]];
    end
    return w;
  endfunction

endpackage

// ===== rtl/wildcard_byte_pattern_scan.sv =====
// A result reaches the output through stage A and stage B of the result path.
// Throughput: one byte per cycle while the input is not stalled; every window
// position has its own compare cell. The result path holds two items; the input
// stalls only while both hold results and the output is stalled.
// Reset (rst_ni low, asynchronous): window and byte count cleared, registers back
// to zero with pattern length 1, no result pending.
module wildcard_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN_BYTES = 32,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  wbps_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output wbps_pkg::out_item_t               out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [63:0]                       cfg_data_i
);

  localparam int unsigned LEN_W = wbps_pkg::LEN_W;
  localparam int unsigned POS_W = wbps_pkg::POS_W;

  // Configuration registers
  logic [63:0]                        base_q, base_d;
  logic [wbps_pkg::PAT_VEC_W-1:0]     pat_q, pat_d;
  logic [wbps_pkg::REG_PAT_BYTES-1:0] mask_q, mask_d;
  logic [wbps_pkg::PLEN_REG_W-1:0]    plen_q, plen_d;

  // Region state
  logic [OFFSET_BITS-1:0] count_q, count_d, count_inc;
  logic                   done_q, done_d;

  logic                   accept, ready, match, push, len_ok;
  logic [LEN_W-1:0]       eff_len;
  logic [OFFSET_BITS-1:0] offset;
  wbps_pkg::cell_ctrl_t   cell_ctrl;
  logic [7:0]             win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  assign cfg_ready_o = 1'b1;

  // Register writes
  always_comb begin
    base_d = base_q;
    pat_d  = pat_q;
    mask_d = mask_q;
    plen_d = plen_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        wbps_pkg::REG_REGION_BASE:    base_d         = cfg_data_i;
        wbps_pkg::REG_PATTERN_BYTES0: pat_d[63:0]    = cfg_data_i;
        wbps_pkg::REG_PATTERN_BYTES1: pat_d[127:64]  = cfg_data_i;
        wbps_pkg::REG_PATTERN_BYTES2: pat_d[191:128] = cfg_data_i;
        wbps_pkg::REG_PATTERN_BYTES3: pat_d[255:192] = cfg_data_i;
        wbps_pkg::REG_WILDCARD_MASK:  mask_d = cfg_data_i[wbps_pkg::REG_PAT_BYTES-1:0];
        wbps_pkg::REG_PATTERN_LENGTH: plen_d = cfg_data_i[wbps_pkg::PLEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      pat_q  <= '0;
      mask_q <= '0;
      plen_q <= wbps_pkg::PLEN_REG_W'(1);
    end else begin
      base_q <= base_d;
      pat_q  <= pat_d;
      mask_q <= mask_d;
      plen_q <= plen_d;
    end
  end

  // Effective length: zero acts as one, clamp to the window depth
  always_comb begin
    eff_len = LEN_W'(plen_q);
    if (plen_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (eff_len > LEN_W'(MAX_PATTERN_BYTES)) begin
      eff_len = LEN_W'(MAX_PATTERN_BYTES);
    end
  end

  assign accept = in_valid_i && ready;
  assign in_stall_o = !ready;

  assign cell_ctrl.load  = accept && !done_q;
  assign cell_ctrl.clear = accept && in_item_i.last_byte;

  // Window cells: entry 0 takes the new byte, entry k the byte of entry k-1
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [LEN_W-1:0] pos;
    logic             active;
    logic [7:0]       nbr;

    // Entry k lines up with pattern position len-1-k
    assign pos    = eff_len - LEN_W'(k + 1);
    assign active = LEN_W'(k) < eff_len;

    if (k == 0) begin : g_head
      assign nbr = in_item_i.data_byte;
    end else begin : g_body
      assign nbr = win[k-1];
    end

    wbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .byte_i     (nbr),
      .exp_byte_i (wbps_pkg::pat_byte(pat_q, pos[POS_W-1:0])),
      .skip_i     (!active || wbps_pkg::pat_wild(mask_q, pos[POS_W-1:0])),
      .byte_o     (win[k]),
      .hit_o      (hits[k])
    );
  end

  // Saturating byte count and match decision for this item
  assign count_inc = (count_q == {OFFSET_BITS{1'b1}}) ? count_q
                                                       : count_q + OFFSET_BITS'(1);
  assign len_ok    = count_inc >= OFFSET_BITS'(eff_len);
  assign match     = !done_q && len_ok && (&hits);
  assign offset    = count_inc - OFFSET_BITS'(eff_len);
  assign push      = accept && (match || (in_item_i.last_byte && !done_q));

  always_comb begin
    count_d = count_q;
    done_d  = done_q;
    if (accept) begin
      if (in_item_i.last_byte) begin
        count_d = '0;
        done_d  = 1'b0;
      end else if (!done_q) begin
        count_d = count_inc;
        if (match) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Result pipe and address add
  wbps_result #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .found_i     (match),
    .offset_i    (offset),
    .base_i      (base_q),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/wbps_cell.sv =====
module wbps_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wbps_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]           byte_i,
  input  logic [7:0]           exp_byte_i,
  input  logic                 skip_i,
  output logic [7:0]           byte_o,
  output logic                 hit_o
);

  logic [7:0] byte_d, byte_q;

  // One window entry: clear wins over the shift
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctrl_i.load) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  // Compare the byte this entry is about to hold
  assign hit_o  = skip_i | (byte_i == exp_byte_i);
  assign byte_o = byte_q;

endmodule

// ===== rtl/wbps_result.sv =====
module wbps_result #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic                    found_i,
  input  logic [OFFSET_BITS-1:0]  offset_i,
  input  logic [63:0]             base_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output wbps_pkg::out_item_t     out_item_o
);

  logic                   a_valid_d, a_valid_q;
  logic                   a_found_d, a_found_q;
  logic [OFFSET_BITS-1:0] a_off_d, a_off_q;
  logic                   b_valid_d, b_valid_q;
  wbps_pkg::out_item_t    b_item_d, b_item_q;
  logic                   a_free, b_free;

  assign b_free  = !b_valid_q || !out_stall_i;
  assign a_free  = !a_valid_q || b_free;
  assign ready_o = a_free;

  // Stage A: hit flag and offset; stage B: address add, output register
  always_comb begin
    a_valid_d = a_valid_q;
    a_found_d = a_found_q;
    a_off_d   = a_off_q;
    b_valid_d = b_valid_q;
    b_item_d  = b_item_q;
    if (a_free) begin
      a_valid_d = push_i;
      if (push_i) begin
        a_found_d = found_i;
        a_off_d   = offset_i;
      end
    end
    if (b_free) begin
      b_valid_d = a_valid_q;
      if (a_valid_q) begin
        b_item_d.found = a_found_q;
        if (a_found_q) begin
          b_item_d.match_address = base_i + 64'(a_off_q);
        end else begin
          b_item_d.match_address = 64'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_found_q <= a_found_d;
    a_off_q   <= a_off_d;
    b_item_q  <= b_item_d;
  end

  assign out_valid_o = b_valid_q;
  assign out_item_o  = b_item_q;

endmodule
